// File: rtl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked while out of reset
`define PCP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcp assertion failed");

// next-cycle implication, checked while out of reset
`define PCP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcp assertion failed");

`endif

// File: rtl/pcp_pkg.sv
// types, constants and register codes of the coincidence preselect
`default_nettype none

package pcp_pkg;

    localparam int DEF_MAX_PULSES   = 32;
    localparam int DEF_NUM_GROUPS   = 2;
    localparam int DEF_NUM_CHANNELS = 64;

    // the register map carries two group masks
    localparam int GROUP_LIMIT = 2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic signed [19:0] TIME_LOW_RST  = 20'sd0;
    localparam logic signed [19:0] TIME_HIGH_RST = 20'sd524287;
    localparam logic [15:0]        PE_MIN_RST    = 16'd0;
    localparam logic [1:0]         GROUP_CNT_RST = 2'd1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TIME_LOW        = 3'd0,
        REG_TIME_HIGH       = 3'd1,
        REG_PE_MIN          = 3'd2,
        REG_GROUP_ZERO_MASK = 3'd3,
        REG_GROUP_ONE_MASK  = 3'd4,
        REG_GROUP_COUNT     = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_GROUP = 2'd1,
        ST_READ  = 2'd2,
        ST_CHECK = 2'd3
    } pcp_state_t;

    typedef struct packed {
        logic               pulse_present;
        logic [5:0]         channel;
        logic signed [15:0] height;
        logic signed [19:0] arrival;
        logic [15:0]        photoelectrons;
        logic signed [19:0] arrival_calibrated;
        logic               event_end;
    } pulse_beat_t;

    typedef struct packed {
        logic               group_index;
        logic               passed;
        logic               carries_pulse;
        logic [5:0]         out_channel;
        logic signed [15:0] out_height;
        logic signed [19:0] out_arrival;
        logic [15:0]        out_photoelectrons;
        logic signed [19:0] out_arrival_calibrated;
        logic               overflowed;
        logic               run_last;
    } result_beat_t;

    typedef struct packed {
        logic [5:0]             channel;
        logic signed [15:0]     height;
        logic signed [19:0]     arrival;
        logic [15:0]            photoelectrons;
        logic signed [19:0]     arrival_calibrated;
        logic [GROUP_LIMIT-1:0] keep;
    } pulse_entry_t;

endpackage

`default_nettype wire

// File: rtl/pcp_stream_if.sv
// valid/ready stream channel carrying one payload beat
`default_nettype none

interface pcp_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/pulse_coincidence_preselect_unit.sv
// top level of the multichannel coincidence preselect
//
//  port        dir  beat
//  pulse_in    in   pcp_pkg::pulse_beat_t, one detector pulse or an event close
//  result_out  out  pcp_pkg::result_beat_t, one group result or one kept pulse
//  cfg_*       in   register write, index and 64 bit data
//
// a pulse is taken every cycle while no event is being reported
// an event close visits each group in turn, then walks the store entries up to
// the group's last kept pulse, with one memory read plus one check per entry
// a stalled result port holds the walk; a pulse beat may be taken while the
// last result of an event still waits in the output register
// reset clears event state and registers; the store needs no clearing
`default_nettype none
`include "assert_macros.svh"

module pulse_coincidence_preselect_unit #(
    parameter int MAX_PULSES   = pcp_pkg::DEF_MAX_PULSES,
    parameter int NUM_GROUPS   = pcp_pkg::DEF_NUM_GROUPS,
    parameter int NUM_CHANNELS = pcp_pkg::DEF_NUM_CHANNELS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    pcp_stream_if.sink                              pulse_in,
    pcp_stream_if.source                            result_out,
    input  wire logic                               cfg_we,
    input  wire logic [pcp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [pcp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW = (MAX_PULSES > 1) ? $clog2(MAX_PULSES) : 1;
    localparam int CW = $clog2(MAX_PULSES + 1);
    localparam int GL = pcp_pkg::GROUP_LIMIT;
    localparam logic [1:0] NG_CAP =
        (NUM_GROUPS < GL) ? 2'(NUM_GROUPS) : 2'(GL);

    // configuration
    logic signed [19:0]      time_low_reg;
    logic signed [19:0]      time_high_reg;
    logic [15:0]             pe_min_reg;
    logic [NUM_CHANNELS-1:0] grp_mask_reg [GL];
    logic [1:0]              group_count_reg;

    // event state
    pcp_pkg::pcp_state_t     state_reg, state_next;
    logic                    grp_reg;
    logic [AW-1:0]           ptr_reg;
    logic [CW-1:0]           count_reg;
    logic                    ovf_reg;
    logic [NUM_CHANNELS-1:0] hit_reg [GL];
    logic [GL-1:0]           kept_any_reg;
    logic [AW-1:0]           last_kept_reg [GL];

    // output stage
    logic                    out_valid_reg;
    pcp_pkg::result_beat_t   out_data_reg;

    pcp_pkg::pulse_beat_t    in_beat;
    pcp_pkg::pulse_entry_t   wr_entry;
    pcp_pkg::pulse_entry_t   rd_entry;
    logic                    in_acc;
    logic                    store_wr;
    logic                    cuts;
    logic [NUM_CHANNELS-1:0] chbit;
    logic [GL-1:0]           keep;
    logic [1:0]              ng;
    logic                    last_group;
    logic [NUM_CHANNELS-1:0] cur_mask;
    logic                    pass;
    logic                    grp_has;
    logic                    entry_hit;
    logic                    at_end;
    logic                    out_free;

    logic                    load_marker;
    logic                    load_pulse;
    logic                    step_done;
    logic                    finish;
    logic                    ptr_adv;
    logic                    ptr_zero;
    logic                    rd_en;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_low_reg    <= pcp_pkg::TIME_LOW_RST;
            time_high_reg   <= pcp_pkg::TIME_HIGH_RST;
            pe_min_reg      <= pcp_pkg::PE_MIN_RST;
            grp_mask_reg[0] <= '0;
            grp_mask_reg[1] <= '0;
            group_count_reg <= pcp_pkg::GROUP_CNT_RST;
        end
        else if (cfg_we)
        begin
            case (pcp_pkg::cfg_reg_t'(cfg_index))
                pcp_pkg::REG_TIME_LOW:        time_low_reg    <= cfg_data[19:0];
                pcp_pkg::REG_TIME_HIGH:       time_high_reg   <= cfg_data[19:0];
                pcp_pkg::REG_PE_MIN:          pe_min_reg      <= cfg_data[15:0];
                pcp_pkg::REG_GROUP_ZERO_MASK: grp_mask_reg[0] <= cfg_data[NUM_CHANNELS-1:0];
                pcp_pkg::REG_GROUP_ONE_MASK:  grp_mask_reg[1] <= cfg_data[NUM_CHANNELS-1:0];
                pcp_pkg::REG_GROUP_COUNT:     group_count_reg <= cfg_data[1:0];
                default:                      ;
            endcase
        end
    end

    // active group count: zero acts as one, capped by the map and the build
    always_comb
    begin
        ng = (group_count_reg == 2'd0) ? 2'd1 :
             (group_count_reg > 2'd2)  ? 2'd2 : group_count_reg;
        if (ng > NG_CAP)
        begin
            ng = NG_CAP;
        end
    end

    // ingest
    assign in_beat  = pulse_in.payload;
    assign in_acc   = pulse_in.valid && pulse_in.ready;
    assign store_wr = in_acc && in_beat.pulse_present && (count_reg < CW'(MAX_PULSES));

    assign cuts  = (in_beat.arrival > time_low_reg) && (in_beat.arrival < time_high_reg)
                   && (in_beat.photoelectrons > pe_min_reg);
    assign chbit = NUM_CHANNELS'(64'd1 << in_beat.channel);

    always_comb
    begin
        for (int g = 0; g < GL; g++)
        begin
            keep[g] = cuts && (2'(g) < ng) && (|(grp_mask_reg[g] & chbit));
        end
    end

    always_comb
    begin
        wr_entry.channel            = in_beat.channel;
        wr_entry.height             = in_beat.height;
        wr_entry.arrival            = in_beat.arrival;
        wr_entry.photoelectrons     = in_beat.photoelectrons;
        wr_entry.arrival_calibrated = in_beat.arrival_calibrated;
        wr_entry.keep               = keep;
    end

    pcp_pulse_store #(
        .DEPTH (MAX_PULSES),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_wr),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (ptr_reg),
        .rd_data (rd_entry)
    );

    // reporting conditions
    assign last_group = (ng == 2'd1) || grp_reg;
    assign cur_mask   = grp_mask_reg[grp_reg];
    assign pass       = (hit_reg[grp_reg] & cur_mask) == cur_mask;
    assign grp_has    = pass && kept_any_reg[grp_reg];
    assign entry_hit  = rd_entry.keep[grp_reg];
    assign at_end     = ptr_reg == last_kept_reg[grp_reg];
    assign out_free   = !out_valid_reg || result_out.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pcp_pkg::ST_IDLE:
            begin
                if (in_acc && in_beat.event_end)
                begin
                    state_next = pcp_pkg::ST_GROUP;
                end
            end
            pcp_pkg::ST_GROUP:
            begin
                if (grp_has)
                begin
                    state_next = pcp_pkg::ST_READ;
                end
                else if (out_free && last_group)
                begin
                    state_next = pcp_pkg::ST_IDLE;
                end
            end
            pcp_pkg::ST_READ:
            begin
                state_next = pcp_pkg::ST_CHECK;
            end
            pcp_pkg::ST_CHECK:
            begin
                if (!entry_hit || out_free)
                begin
                    if (!at_end)
                    begin
                        state_next = pcp_pkg::ST_READ;
                    end
                    else if (last_group)
                    begin
                        state_next = pcp_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = pcp_pkg::ST_GROUP;
                    end
                end
            end
            default:
            begin
                state_next = pcp_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        load_marker = 1'b0;
        load_pulse  = 1'b0;
        step_done   = 1'b0;
        ptr_adv     = 1'b0;
        ptr_zero    = 1'b0;
        rd_en       = 1'b0;
        case (state_reg)
            pcp_pkg::ST_IDLE:
            begin
            end
            pcp_pkg::ST_GROUP:
            begin
                ptr_zero    = grp_has;
                load_marker = !grp_has && out_free;
                step_done   = !grp_has && out_free;
            end
            pcp_pkg::ST_READ:
            begin
                rd_en = 1'b1;
            end
            pcp_pkg::ST_CHECK:
            begin
                load_pulse = entry_hit && out_free;
                step_done  = (!entry_hit || out_free) && at_end;
                ptr_adv    = (!entry_hit || out_free) && !at_end;
            end
            default:
            begin
            end
        endcase
    end

    assign finish = step_done && last_group;
    assign pulse_in.ready = (state_reg == pcp_pkg::ST_IDLE);

    // control and event state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pcp_pkg::ST_IDLE;
            grp_reg          <= 1'b0;
            ptr_reg          <= '0;
            count_reg        <= '0;
            ovf_reg          <= 1'b0;
            kept_any_reg     <= '0;
            for (int g = 0; g < GL; g++)
            begin
                hit_reg[g]       <= '0;
                last_kept_reg[g] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc && in_beat.event_end)
            begin
                grp_reg <= 1'b0;
            end
            else if (step_done && !last_group)
            begin
                grp_reg <= 1'b1;
            end
            if (ptr_zero)
            begin
                ptr_reg <= '0;
            end
            else if (ptr_adv)
            begin
                ptr_reg <= AW'(ptr_reg + 1'b1);
            end
            if (finish)
            begin
                count_reg    <= '0;
                ovf_reg      <= 1'b0;
                kept_any_reg <= '0;
                for (int g = 0; g < GL; g++)
                begin
                    hit_reg[g] <= '0;
                end
            end
            else if (store_wr)
            begin
                count_reg <= CW'(count_reg + 1'b1);
                for (int g = 0; g < GL; g++)
                begin
                    if (keep[g])
                    begin
                        hit_reg[g]       <= hit_reg[g] | chbit;
                        kept_any_reg[g]  <= 1'b1;
                        last_kept_reg[g] <= count_reg[AW-1:0];
                    end
                end
            end
            else if (in_acc && in_beat.pulse_present)
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_marker || load_pulse)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_marker)
        begin
            out_data_reg                        <= '0;
            out_data_reg.group_index            <= grp_reg;
            out_data_reg.passed                 <= pass;
            out_data_reg.overflowed             <= ovf_reg;
            out_data_reg.run_last               <= last_group;
        end
        else if (load_pulse)
        begin
            out_data_reg.group_index            <= grp_reg;
            out_data_reg.passed                 <= 1'b1;
            out_data_reg.carries_pulse          <= 1'b1;
            out_data_reg.out_channel            <= rd_entry.channel;
            out_data_reg.out_height             <= rd_entry.height;
            out_data_reg.out_arrival            <= rd_entry.arrival;
            out_data_reg.out_photoelectrons     <= rd_entry.photoelectrons;
            out_data_reg.out_arrival_calibrated <= rd_entry.arrival_calibrated;
            out_data_reg.overflowed             <= ovf_reg;
            out_data_reg.run_last               <= at_end && last_group;
        end
    end

    assign result_out.valid   = out_valid_reg;
    assign result_out.payload = out_data_reg;

    // checks
    `PCP_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(MAX_PULSES))
    `PCP_ASSERT_NEXT(a_close_starts_report, in_acc && in_beat.event_end,
        state_reg == pcp_pkg::ST_GROUP)
    `PCP_ASSERT_NEXT(a_finish_clears, finish,
        state_reg == pcp_pkg::ST_IDLE && count_reg == '0 && !ovf_reg)
    `PCP_ASSERT_NOW(a_walk_bound, state_reg == pcp_pkg::ST_CHECK,
        ptr_reg <= last_kept_reg[grp_reg])

endmodule

`default_nettype wire

// File: rtl/pcp_pulse_store.sv
// pulse store memory, one write and one registered read port
`default_nettype none

module pcp_pulse_store #(
    parameter int DEPTH = pcp_pkg::DEF_MAX_PULSES,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 clk,
    input  wire logic                 wr_en,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire pcp_pkg::pulse_entry_t wr_data,
    input  wire logic                 rd_en,
    input  wire logic [AW-1:0]        rd_addr,
    output pcp_pkg::pulse_entry_t     rd_data
);

    pcp_pkg::pulse_entry_t mem [DEPTH];
    pcp_pkg::pulse_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: sim/testbench.sv
// testbench for the coincidence preselect: directed table, random events, predicted results
module testbench;

    localparam int STALL_LIMIT = 4000;
    localparam int STORE_DEPTH = 32;

    typedef struct {
        logic                  is_cfg;
        pcp_pkg::cfg_reg_t     reg_id;
        logic [63:0]           value;
        pcp_pkg::pulse_beat_t  beat;
        int                    reps;
        logic                  typed;
        pcp_pkg::result_beat_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [pcp_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [pcp_pkg::CFG_DATA_W-1:0]  cfg_data;

    pcp_stream_if #(.payload_t(pcp_pkg::pulse_beat_t))  pulse_if ();
    pcp_stream_if #(.payload_t(pcp_pkg::result_beat_t)) result_if ();

    pulse_coincidence_preselect_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pulse_in   (pulse_if),
        .result_out (result_if),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // predictor state
    logic signed [19:0]    win_lo;
    logic signed [19:0]    win_hi;
    logic [15:0]           pe_min;
    logic [63:0]           group_mask [2];
    logic [1:0]            group_count;
    pcp_pkg::pulse_entry_t kept_store [STORE_DEPTH];
    logic [63:0]           hit_mask [2];
    int                    stored_count;
    logic                  overflow_seen;

    pcp_pkg::result_beat_t pending_results [$];
    pcp_pkg::result_beat_t event_results [$];
    int                    chan_pool [$];

    int   mismatch_count = 0;
    int   stall_cycles = 0;
    logic idle_on = 1'b1;
    logic hold_req = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic evaluate_pulse(input pcp_pkg::pulse_beat_t b);
        int                    ng;
        int                    g;
        int                    p;
        int                    given;
        logic                  cuts;
        logic                  all_hit;
        logic [63:0]           chbit;
        logic [1:0]            keep;
        pcp_pkg::result_beat_t r;
        event_results.delete();
        ng = (group_count == 2'd0) ? 1 : ((group_count == 2'd3) ? 2 : int'(group_count));
        if (b.pulse_present)
        begin
            cuts = $signed(b.arrival) > win_lo && $signed(b.arrival) < win_hi
                && b.photoelectrons > pe_min;
            chbit = 64'd1 << b.channel;
            if (stored_count < STORE_DEPTH)
            begin
                keep = '0;
                for (g = 0; g < ng; g++)
                begin
                    if (cuts && (group_mask[g] & chbit) != 64'd0)
                    begin
                        keep[g] = 1'b1;
                        hit_mask[g] |= chbit;
                    end
                end
                kept_store[stored_count] = {b.channel, b.height, b.arrival, b.photoelectrons,
                    b.arrival_calibrated, keep};
                stored_count++;
            end
            else
                overflow_seen = 1'b1;
        end
        if (b.event_end)
        begin
            for (g = 0; g < ng; g++)
            begin
                given = 0;
                all_hit = (hit_mask[g] & group_mask[g]) == group_mask[g];
                if (all_hit)
                begin
                    for (p = 0; p < stored_count; p++)
                    begin
                        if (kept_store[p].keep[g])
                        begin
                            r = '0;
                            r.group_index = 1'(g);
                            r.passed = 1'b1;
                            r.carries_pulse = 1'b1;
                            r.out_channel = kept_store[p].channel;
                            r.out_height = kept_store[p].height;
                            r.out_arrival = kept_store[p].arrival;
                            r.out_photoelectrons = kept_store[p].photoelectrons;
                            r.out_arrival_calibrated = kept_store[p].arrival_calibrated;
                            r.overflowed = overflow_seen;
                            event_results = {event_results, r};
                            given++;
                        end
                    end
                end
                if (given == 0)
                begin
                    r = '0;
                    r.group_index = 1'(g);
                    r.passed = all_hit;
                    r.overflowed = overflow_seen;
                    event_results = {event_results, r};
                end
            end
            event_results[event_results.size() - 1].run_last = 1'b1;
            hit_mask[0] = '0;
            hit_mask[1] = '0;
            stored_count = 0;
            overflow_seen = 1'b0;
        end
    endtask

    function automatic string describe(input pcp_pkg::result_beat_t r);
        return $sformatf(
            "grp %0d pass %0d pulse %0d ch %0d ht %0d t %0d pe %0d tc %0d ovf %0d last %0d",
            r.group_index, r.passed, r.carries_pulse, r.out_channel, r.out_height, r.out_arrival,
            r.out_photoelectrons, r.out_arrival_calibrated, r.overflowed, r.run_last);
    endfunction

    task automatic check_result(input pcp_pkg::result_beat_t got);
        pcp_pkg::result_beat_t want;
        if (pending_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected result beat: %s", describe(got));
            return;
        end
        want = pending_results.pop_front();
        if (got.group_index !== want.group_index || got.passed !== want.passed
            || got.carries_pulse !== want.carries_pulse || got.out_channel !== want.out_channel
            || got.out_height !== want.out_height || got.out_arrival !== want.out_arrival
            || got.out_photoelectrons !== want.out_photoelectrons
            || got.out_arrival_calibrated !== want.out_arrival_calibrated
            || got.overflowed !== want.overflowed || got.run_last !== want.run_last)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("result mismatch\n  expected %s\n  actual   %s",
                    describe(want), describe(got));
        end
    endtask

    task automatic send_pulse(input pcp_pkg::pulse_beat_t b, input logic typed,
        input pcp_pkg::result_beat_t want);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            pulse_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        pulse_if.valid <= 1'b1;
        pulse_if.payload <= b;
        do
            @(posedge clk);
        while (!pulse_if.ready);
        evaluate_pulse(b);
        if (typed)
            pending_results = {pending_results, want};
        else
            pending_results = {pending_results, event_results};
    endtask

    task automatic settle();
        pulse_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input pcp_pkg::cfg_reg_t idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            pcp_pkg::REG_TIME_LOW:        win_lo = val[19:0];
            pcp_pkg::REG_TIME_HIGH:       win_hi = val[19:0];
            pcp_pkg::REG_PE_MIN:          pe_min = val[15:0];
            pcp_pkg::REG_GROUP_ZERO_MASK: group_mask[0] = val;
            pcp_pkg::REG_GROUP_ONE_MASK:  group_mask[1] = val;
            pcp_pkg::REG_GROUP_COUNT:     group_count = val[1:0];
            default:                      ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic stim_row_t cfg_row(input pcp_pkg::cfg_reg_t idx, input logic [63:0] val);
        stim_row_t r;
        r.is_cfg = 1'b1;
        r.reg_id = idx;
        r.value = val;
        r.beat = '0;
        r.reps = 1;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic stim_row_t beat_row(input logic pp, input logic [5:0] ch,
        input logic signed [15:0] h, input logic signed [19:0] t, input logic [15:0] pe,
        input logic signed [19:0] tc, input logic ee);
        stim_row_t r;
        r.is_cfg = 1'b0;
        r.reg_id = pcp_pkg::REG_TIME_LOW;
        r.value = '0;
        r.beat = {pp, ch, h, t, pe, tc, ee};
        r.reps = 1;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic pcp_pkg::result_beat_t marker(input logic g, input logic ok);
        pcp_pkg::result_beat_t r;
        r = '0;
        r.group_index = g;
        r.passed = ok;
        r.run_last = 1'b1;
        return r;
    endfunction

    function automatic pcp_pkg::pulse_beat_t noise_beat();
        pcp_pkg::pulse_beat_t b;
        logic [95:0]          raw;
        raw = {$urandom, $urandom, $urandom};
        b = raw[79:0];
        b.pulse_present = 1'b0;
        b.event_end = 1'b0;
        return b;
    endfunction

    function automatic pcp_pkg::pulse_beat_t make_pulse(input logic last);
        pcp_pkg::pulse_beat_t b;
        logic [95:0]          raw;
        int                   lo_i;
        int                   hi_i;
        int                   pe_i;
        raw = {$urandom, $urandom, $urandom};
        b = raw[79:0];
        b.pulse_present = 1'b1;
        b.event_end = last;
        lo_i = win_lo;
        hi_i = win_hi;
        if (chan_pool.size() != 0 && $urandom_range(0, 3) != 0)
            b.channel = 6'(chan_pool[$urandom_range(0, chan_pool.size() - 1)]);
        case ($urandom_range(0, 9))
            0:       b.arrival = win_lo;
            1:       b.arrival = win_hi;
            2:       ;
            default:
                if (hi_i - lo_i > 1)
                    b.arrival = 20'(lo_i + 1 + int'($urandom_range(0, hi_i - lo_i - 2)));
        endcase
        if ($urandom_range(0, 7) != 0)
        begin
            pe_i = int'(pe_min) + 1 + int'($urandom_range(0, 2000));
            b.photoelectrons = (pe_i > 65535) ? 16'hffff : 16'(pe_i);
        end
        return b;
    endfunction

    function automatic logic [63:0] pick_mask();
        logic [63:0] m;
        int          ch;
        m = '0;
        repeat ($urandom_range(0, 4))
        begin
            ch = $urandom_range(0, 63);
            m[ch] = 1'b1;
            chan_pool = {chan_pool, ch};
        end
        return m;
    endfunction

    // result side: checks and random backpressure
    initial
    begin : result_sink
        int   hold_left;
        logic hold_taken;
        hold_left = 0;
        hold_taken = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_if.valid && result_if.ready)
                check_result(result_if.payload);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_if.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                hold_left = $urandom_range(1, 12) - 1;
                result_if.ready <= 1'b0;
            end
            else
                result_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pulse_if.valid && pulse_if.ready) || (result_if.valid && result_if.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : stimulus
        stim_row_t            plan [$];
        stim_row_t            row;
        pcp_pkg::pulse_beat_t b;
        logic [63:0]          d;
        int                   phase;
        int                   phase_items;
        int                   n;
        int                   i;
        int                   lo_i;
        int                   hi_i;
        logic                 split_close;

        rst_n = 1'b0;
        pulse_if.valid = 1'b0;
        pulse_if.payload = '0;
        result_if.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        win_lo = pcp_pkg::TIME_LOW_RST;
        win_hi = pcp_pkg::TIME_HIGH_RST;
        pe_min = pcp_pkg::PE_MIN_RST;
        group_mask[0] = '0;
        group_mask[1] = '0;
        group_count = pcp_pkg::GROUP_CNT_RST;
        hit_mask[0] = '0;
        hit_mask[1] = '0;
        stored_count = 0;
        overflow_seen = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty masks pass with no kept pulse
        row = beat_row(1'b0, 6'h3f, 16'hffff, 20'hfffff, 16'hffff, 20'hfffff, 1'b1);
        row.typed = 1'b1;
        row.want = marker(1'b0, 1'b1);
        plan = {plan, row};
        plan = {plan, beat_row(1'b0, 6'h3f, 16'hffff, 20'hfffff, 16'hffff, 20'hfffff, 1'b0)};
        plan = {plan, beat_row(1'b1, 6'd5, 16'sd7, 20'sd100, 16'd16, 20'sd90, 1'b0)};
        row = beat_row(1'b0, 6'd0, 16'sd0, 20'sd0, 16'd0, 20'sd0, 1'b1);
        row.typed = 1'b1;
        row.want = marker(1'b0, 1'b1);
        plan = {plan, row};

        // extremes of every field, lower window edge excluded
        plan = {plan, cfg_row(pcp_pkg::REG_GROUP_ZERO_MASK, 64'h8000_0000_0000_0020)};
        plan = {plan, cfg_row(pcp_pkg::REG_GROUP_ONE_MASK, 64'hffff_ffff_ffff_ffff)};
        plan = {plan, cfg_row(pcp_pkg::REG_GROUP_COUNT, 64'h2)};
        plan = {plan, beat_row(1'b1, 6'd63, 16'h8000, 20'sd1, 16'hffff, 20'h80000, 1'b0)};
        plan = {plan, beat_row(1'b1, 6'd5, 16'h7fff, 20'h7fffe, 16'd1, 20'h7ffff, 1'b0)};
        plan = {plan, beat_row(1'b1, 6'd0, 16'sd0, 20'sd0, 16'd100, 20'sd0, 1'b1)};

        // nothing is above the largest minimum
        plan = {plan, cfg_row(pcp_pkg::REG_TIME_LOW, 64'hdead_beef_1238_0000)};
        plan = {plan, cfg_row(pcp_pkg::REG_TIME_HIGH, 64'h0000_0000_0007_ffff)};
        plan = {plan, cfg_row(pcp_pkg::REG_PE_MIN, 64'hffff_ffff_ffff_ffff)};
        plan = {plan, beat_row(1'b1, 6'd5, 16'sd3, 20'sd0, 16'hffff, 20'sd0, 1'b1)};

        // empty window, group count zero acts as one
        plan = {plan, cfg_row(pcp_pkg::REG_PE_MIN, 64'h0)};
        plan = {plan, cfg_row(pcp_pkg::REG_GROUP_COUNT, 64'h4)};
        plan = {plan, cfg_row(pcp_pkg::REG_TIME_LOW, 64'd100)};
        plan = {plan, cfg_row(pcp_pkg::REG_TIME_HIGH, 64'd100)};
        row = beat_row(1'b1, 6'd5, 16'sd9, 20'sd100, 16'd50, 20'sd100, 1'b1);
        row.typed = 1'b1;
        row.want = marker(1'b0, 1'b0);
        plan = {plan, row};

        // both window edges excluded, group count three limited to two
        plan = {plan, cfg_row(pcp_pkg::REG_TIME_LOW, 64'h80000)};
        plan = {plan, cfg_row(pcp_pkg::REG_TIME_HIGH, 64'h7ffff)};
        plan = {plan, cfg_row(pcp_pkg::REG_GROUP_ZERO_MASK, 64'h1)};
        plan = {plan, cfg_row(pcp_pkg::REG_GROUP_ONE_MASK, 64'h3)};
        plan = {plan, cfg_row(pcp_pkg::REG_GROUP_COUNT, 64'h3)};
        plan = {plan, beat_row(1'b1, 6'd0, 16'sd1, 20'h80000, 16'd1, 20'sd1, 1'b0)};
        plan = {plan, beat_row(1'b1, 6'd0, 16'sd2, 20'h80001, 16'd1, 20'sd2, 1'b0)};
        plan = {plan, beat_row(1'b1, 6'd1, 16'sd3, 20'h7ffff, 16'd1, 20'sd3, 1'b0)};
        plan = {plan, beat_row(1'b1, 6'd1, 16'sd4, 20'h7fffe, 16'd1, 20'sd4, 1'b1)};

        // store full: the dropped pulse is no hit
        row = beat_row(1'b1, 6'd0, -16'sd5, 20'sd10, 16'd5, -20'sd10, 1'b0);
        row.reps = STORE_DEPTH;
        plan = {plan, row};
        plan = {plan, beat_row(1'b1, 6'd1, 16'sd6, 20'sd20, 16'd5, 20'sd20, 1'b0)};
        plan = {plan, beat_row(1'b0, 6'd1, 16'sd0, 20'sd0, 16'd0, 20'sd0, 1'b1)};
        plan = {plan, beat_row(1'b0, 6'd0, 16'sd0, 20'sd0, 16'd0, 20'sd0, 1'b1)};

        foreach (plan[k])
        begin
            if (plan[k].is_cfg)
            begin
                settle();
                write_reg(plan[k].reg_id, plan[k].value);
            end
            else
                repeat (plan[k].reps)
                    send_pulse(plan[k].beat, plan[k].typed, plan[k].want);
        end

        for (phase = 0; phase < 6; phase++)
        begin
            if (phase == 5)
                idle_on = 1'b0;
            settle();
            chan_pool.delete();
            lo_i = (phase == 4) ? -524288 : int'($urandom_range(0, 4000)) - 2000;
            hi_i = (phase == 4) ? 524287 : lo_i + int'($urandom_range(300, 5000));
            d = {$urandom, $urandom};
            d[19:0] = 20'(lo_i);
            write_reg(pcp_pkg::REG_TIME_LOW, d);
            d = {$urandom, $urandom};
            d[19:0] = 20'(hi_i);
            write_reg(pcp_pkg::REG_TIME_HIGH, d);
            d = {$urandom, $urandom};
            d[15:0] = (phase == 4) ? 16'd0 : 16'($urandom_range(0, 500));
            write_reg(pcp_pkg::REG_PE_MIN, d);
            write_reg(pcp_pkg::REG_GROUP_ZERO_MASK, pick_mask());
            write_reg(pcp_pkg::REG_GROUP_ONE_MASK,
                (phase == 2) ? 64'hffff_ffff_ffff_ffff : pick_mask());
            d = {$urandom, $urandom};
            d[1:0] = (phase == 0) ? 2'd2 : 2'($urandom_range(0, 3));
            write_reg(pcp_pkg::REG_GROUP_COUNT, d);
            if (phase == 0)
                hold_req = 1'b1;

            phase_items = 0;
            while (phase_items < 14)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 6);
                split_close = (n == 0) || ($urandom_range(0, 1) == 0);
                for (i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 7) == 0)
                        send_pulse(noise_beat(), 1'b0, '0);
                    send_pulse(make_pulse(!split_close && i == n - 1), 1'b0, '0);
                    phase_items++;
                end
                if (split_close)
                begin
                    b = noise_beat();
                    b.event_end = 1'b1;
                    send_pulse(b, 1'b0, '0);
                    phase_items++;
                end
            end
        end

        settle();
        repeat (80) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/pcp_pkg.sv
rtl/pcp_stream_if.sv
rtl/pcp_pulse_store.sv
rtl/pulse_coincidence_preselect_unit.sv
sim/testbench.sv
